@@ hw/rtl/rlf_pkg.sv @@
// ----------------------------------------------------------------------------
// rlf_pkg: shared types and constants of the rgb led fade controller
// Holds field widths, opcodes, the default group count and the command and
// status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package rlf_pkg;

   // default number of lamp groups
   localparam int GROUPS_DEF = 3;

   // colors per group
   localparam int COLORS = 3;

   // field widths
   localparam int GRP_W  = 2;
   localparam int BYTE_W = 8;
   localparam int CH_W   = 4;
   localparam int DUTY_W = 10;

   // opcodes of an input transfer
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET  = 1'b1;

   // color slots inside a group
   localparam logic [1:0] COL_RED   = 2'd0;
   localparam logic [1:0] COL_GREEN = 2'd1;
   localparam logic [1:0] COL_BLUE  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic       load;         // capture the input transfer
      logic       store_color;  // convert color and store targets
      logic       grp_eval;     // advance the tick counter of one group
      logic       chan_step;    // examine one channel of the group
      logic       flush;        // release the held result as the last one
      logic [1:0] chan;         // color slot for chan_step
   } rlf_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic chan_go;   // channel step can complete this cycle
      logic flush_go;  // flush can complete this cycle
   } rlf_sts_type;

endpackage

@@ hw/rtl/rlf_datapath.sv @@
// ----------------------------------------------------------------------------
// rlf_datapath: storage and arithmetic of the rgb led fade controller
// Holds target and current duties, fade periods and tick counters per group,
// converts hue and intensity to rgb, and drives the result register through
// a one-entry hold stage that lets the final write carry the last flag.
// ----------------------------------------------------------------------------
module rlf_datapath #(
   parameter int GROUPS = rlf_pkg::GROUPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rlf_pkg::rlf_cmd_type           cmd,
   input  logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] grp_idx,
   output rlf_pkg::rlf_sts_type           sts,
   input  logic                           req_op,
   input  logic [rlf_pkg::GRP_W-1:0]      req_group,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_hue,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_intensity,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_fade_period,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rlf_pkg::CH_W-1:0]       rsp_channel,
   output logic [rlf_pkg::DUTY_W-1:0]     rsp_duty,
   output logic                           rsp_last
);
   import rlf_pkg::*;

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // captured input transfer
   logic              op_ff;
   logic [GRP_W-1:0]  grp_ff;
   logic [BYTE_W-1:0] hue_ff;
   logic [BYTE_W-1:0] int_ff;
   logic [BYTE_W-1:0] per_ff;

   // per group state
   logic [COLORS-1:0][DUTY_W-1:0] tgt_ff [GROUPS];
   logic [COLORS-1:0][DUTY_W-1:0] cur_ff [GROUPS];
   logic [BYTE_W-1:0]             prd_ff [GROUPS];
   logic [BYTE_W-1:0]             cnt_ff [GROUPS];

   // group decision for the channel steps
   logic jump_ff;
   logic step_ff;

   // held result and result register
   logic              pend_vld_ff;
   logic [CH_W-1:0]   pend_ch_ff;
   logic [DUTY_W-1:0] pend_duty_ff;
   logic              out_vld_ff;
   logic [CH_W-1:0]   out_ch_ff;
   logic [DUTY_W-1:0] out_duty_ff;
   logic              out_last_ff;

   // color conversion signals
   logic [9:0]         hue3;
   logic [1:0]         sector;
   logic [7:0]         frac;
   logic [7:0]         frac_sc;
   logic [15:0]        prod;
   logic [7:0]         xval;
   logic [7:0]         bmx;
   logic [7:0]         red;
   logic [7:0]         green;
   logic [7:0]         blue;
   logic [4:0]         grp_ext;
   logic [GW-1:0]      grp_w;
   logic               grp_ok;

   // tick signals
   logic [BYTE_W-1:0] prd_sel;
   logic [BYTE_W-1:0] cnt_inc;
   logic              jump_in;
   logic              step_in;
   logic [DUTY_W-1:0] cur_sel;
   logic [DUTY_W-1:0] tgt_sel;
   logic              differ;
   logic              cand;
   logic [DUTY_W-1:0] cand_duty;
   logic [5:0]        ch_full;
   logic              out_free;
   logic              chan_fire;
   logic              flush_fire;

   // capture the accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         grp_ff <= req_group;
         hue_ff <= req_hue;
         int_ff <= req_intensity;
         per_ff <= req_fade_period;
      end
   end

   // hue to rgb at full saturation, hue scaled by three
   always_comb begin
      hue3    = {1'b0, hue_ff, 1'b0} + {2'b00, hue_ff};
      sector  = hue3[9:8];
      frac    = hue3[7:0];
      // (frac * 255) >> 8 equals frac - 1 for nonzero frac
      frac_sc = (frac == 8'd0) ? 8'd0 : frac - 8'd1;
      prod    = frac_sc * int_ff;
      xval    = prod[15:8];
      bmx     = int_ff - xval;
      case (sector)
         2'd1: begin
            red   = 8'd0;
            green = bmx;
            blue  = xval;
         end
         2'd2: begin
            red   = xval;
            green = 8'd0;
            blue  = bmx;
         end
         default: begin
            red   = bmx;
            green = xval;
            blue  = 8'd0;
         end
      endcase
      grp_ext = {3'b000, grp_ff};
      grp_w   = grp_ext[GW-1:0];
      grp_ok  = grp_ext < 5'(GROUPS);
   end

   // group and channel selection for a tick
   always_comb begin
      prd_sel   = prd_ff[grp_idx];
      cnt_inc   = cnt_ff[grp_idx] + 8'd1;
      jump_in   = prd_sel == 8'd0;
      step_in   = !jump_in && (cnt_inc >= prd_sel);
      cur_sel   = cur_ff[grp_idx][cmd.chan];
      tgt_sel   = tgt_ff[grp_idx][cmd.chan];
      differ    = cur_sel != tgt_sel;
      cand      = jump_ff || (step_ff && differ);
      cand_duty = jump_ff ? tgt_sel : cur_sel;
      ch_full   = 6'(grp_idx) * 6'd3 + 6'(cmd.chan);
      out_free  = !out_vld_ff || !rsp_stall;
      chan_fire  = cmd.chan_step && (!(cand && pend_vld_ff) || out_free);
      flush_fire = cmd.flush && (!pend_vld_ff || out_free);
   end

   assign sts.chan_go  = !(cand && pend_vld_ff) || out_free;
   assign sts.flush_go = !pend_vld_ff || out_free;

   // per group state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUPS; g++) begin
            tgt_ff[g] <= '0;
            cur_ff[g] <= '0;
            prd_ff[g] <= '0;
            cnt_ff[g] <= '0;
         end
      end else begin
         if (cmd.store_color && op_ff == OP_SET && grp_ok) begin
            tgt_ff[grp_w][COL_RED]   <= {red, 2'b00};
            tgt_ff[grp_w][COL_GREEN] <= {green, 2'b00};
            tgt_ff[grp_w][COL_BLUE]  <= {blue, 2'b00};
            prd_ff[grp_w]            <= per_ff;
         end
         if (cmd.grp_eval && !jump_in) begin
            cnt_ff[grp_idx] <= step_in ? 8'd0 : cnt_inc;
         end
         if (chan_fire && step_ff && !jump_ff && differ) begin
            cur_ff[grp_idx][cmd.chan] <= (cur_sel < tgt_sel) ? cur_sel + 10'd1
                                                              : cur_sel - 10'd1;
         end
      end
   end

   // group decision
   always_ff @(posedge clock) begin
      if (cmd.grp_eval) begin
         jump_ff <= jump_in;
         step_ff <= step_in;
      end
   end

   // hold stage and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         if (out_vld_ff && !rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
         if (chan_fire && cand) begin
            pend_vld_ff  <= 1'b1;
            pend_ch_ff   <= ch_full[CH_W-1:0];
            pend_duty_ff <= cand_duty;
            if (pend_vld_ff) begin
               out_vld_ff  <= 1'b1;
               out_ch_ff   <= pend_ch_ff;
               out_duty_ff <= pend_duty_ff;
               out_last_ff <= 1'b0;
            end
         end
         if (flush_fire && pend_vld_ff) begin
            pend_vld_ff <= 1'b0;
            out_vld_ff  <= 1'b1;
            out_ch_ff   <= pend_ch_ff;
            out_duty_ff <= pend_duty_ff;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_channel = out_ch_ff;
   assign rsp_duty    = out_duty_ff;
   assign rsp_last    = out_last_ff;

   // a new result only comes from a channel step or a flush
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(cmd.chan_step || cmd.flush))
      else $error("result appeared outside a tick walk");

   // a completed flush leaves nothing held
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      flush_fire |=> !pend_vld_ff)
      else $error("held result survived a flush");

   // jump mode and stepping exclude each other
   a_jump_step: assert property (@(posedge clock) disable iff (reset)
      cmd.grp_eval |=> !(jump_ff && step_ff))
      else $error("group both jumps and steps");

endmodule

@@ hw/rtl/rlf_controller.sv @@
// ----------------------------------------------------------------------------
// rlf_controller: sequencer of the rgb led fade controller
// Accepts one transfer at a time, runs the set color cycle or walks the
// groups and their three channels on a tick, then flushes the last result.
// ----------------------------------------------------------------------------
module rlf_controller #(
   parameter int GROUPS = rlf_pkg::GROUPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  rlf_pkg::rlf_sts_type sts,
   output rlf_pkg::rlf_cmd_type cmd,
   output logic [((GROUPS > 1) ? $clog2(GROUPS) : 1)-1:0] grp_idx
);
   import rlf_pkg::*;

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SET   = 3'd1;
   localparam logic [2:0] S_GRP   = 3'd2;
   localparam logic [2:0] S_CHN   = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]    state_ff;
   logic [2:0]    state_in;
   logic [GW-1:0] grp_ff;
   logic [GW-1:0] grp_in;
   logic [1:0]    chn_ff;
   logic [1:0]    chn_in;
   logic          accept;

   assign accept = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      grp_in        = grp_ff;
      chn_in        = chn_ff;
      req_stall     = 1'b1;
      cmd           = '0;
      cmd.chan      = chn_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               grp_in   = '0;
               state_in = (req_op == OP_SET) ? S_SET : S_GRP;
            end
         end
         S_SET: begin
            cmd.store_color = 1'b1;
            state_in        = S_IDLE;
         end
         S_GRP: begin
            cmd.grp_eval = 1'b1;
            chn_in       = COL_RED;
            state_in     = S_CHN;
         end
         S_CHN: begin
            cmd.chan_step = 1'b1;
            if (sts.chan_go) begin
               if (chn_ff == COL_BLUE) begin
                  if (grp_ff == GW'(GROUPS - 1)) begin
                     state_in = S_FLUSH;
                  end else begin
                     grp_in   = grp_ff + 1'b1;
                     state_in = S_GRP;
                  end
               end else begin
                  chn_in = chn_ff + 2'd1;
               end
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (sts.flush_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         grp_ff   <= '0;
         chn_ff   <= COL_RED;
      end else begin
         state_ff <= state_in;
         grp_ff   <= grp_in;
         chn_ff   <= chn_in;
      end
   end

   assign grp_idx = grp_ff;

   // channel slot stays within the three colors
   a_chn_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CHN |-> chn_ff != 2'd3)
      else $error("channel slot out of range");

   // flush is only reached from the channel walk
   a_flush_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> $past(state_ff == S_CHN || state_ff == S_FLUSH))
      else $error("flush entered without a walk");

   // a tick transfer starts the walk at the first group
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_TICK |=> state_ff == S_GRP && grp_ff == '0)
      else $error("tick walk did not start at group zero");

endmodule

@@ hw/rtl/rgb_led_fade_controller.sv @@
// ----------------------------------------------------------------------------
// rgb_led_fade_controller: hsb to rgb lamp fader with per-group fade timing
// Set color transfers store rgb targets and a fade period per group; tick
// transfers walk all groups and emit the duty writes that the fade causes.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid, req_stall  op, group, hue, intensity,
//                                             fade_period
//   rsp_     out        rsp_valid, rsp_stall  channel, duty, last
//
// set color converts and stores the targets, then returns to ready
// a tick walks each group in turn, its tick counter first and then each of its
//   three channels, and ends with a final flush
// result stalls hold the walk in place at the channel that needs to write
// reset is synchronous and clears all duties, periods and counters
// ----------------------------------------------------------------------------
module rgb_led_fade_controller #(
   parameter int GROUPS = rlf_pkg::GROUPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_op,
   input  logic [rlf_pkg::GRP_W-1:0]      req_group,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_hue,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_intensity,
   input  logic [rlf_pkg::BYTE_W-1:0]     req_fade_period,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rlf_pkg::CH_W-1:0]       rsp_channel,
   output logic [rlf_pkg::DUTY_W-1:0]     rsp_duty,
   output logic                           rsp_last
);
   import rlf_pkg::*;

   localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   rlf_cmd_type   cmd;
   rlf_sts_type   sts;
   logic [GW-1:0] grp_idx;

   // sequencer
   rlf_controller #(
      .GROUPS (GROUPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .sts       (sts),
      .cmd       (cmd),
      .grp_idx   (grp_idx)
   );

   // storage and arithmetic
   rlf_datapath #(
      .GROUPS (GROUPS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .grp_idx         (grp_idx),
      .sts             (sts),
      .req_op          (req_op),
      .req_group       (req_group),
      .req_hue         (req_hue),
      .req_intensity   (req_intensity),
      .req_fade_period (req_fade_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel     (rsp_channel),
      .rsp_duty        (rsp_duty),
      .rsp_last        (rsp_last)
   );

endmodule

@@ sim/rgb_led_fade_controller_tb.sv @@
// ----------------------------------------------------------------------------
// rgb_led_fade_controller_tb: self-checking bench of the rgb led fade controller
// Walks a short table of set-color and tick transfers, then several hundred
// random ones, under random idling on both channels and one long result
// hold-off. Every duty write is checked, against an in-bench fade predictor or a fixed frame.
// ----------------------------------------------------------------------------
module rgb_led_fade_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlf_pkg::*;

   localparam int GROUPS         = GROUPS_DEF;
   localparam int NCH            = GROUPS * COLORS;
   localparam int MAX_DUTY       = 1020;
   localparam int RANDOM_ITEMS   = 450;
   localparam int SQUEEZE_AT     = 60;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 2 + 4 * GROUPS + 20;
   localparam int CYCLE_LIMIT    = 1_000_000;

   localparam logic [NCH-1:0][DUTY_W-1:0] FRAME_DARK = '0;
   localparam logic [NCH-1:0][DUTY_W-1:0] FRAME_RED0 =
      {{((NCH-1)*DUTY_W){1'b0}}, DUTY_W'(MAX_DUTY)};

   typedef enum {CHK_MODEL, CHK_NONE, CHK_FRAME} chk_kind_type;

   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic [DUTY_W-1:0] duty;
      logic              last;
   } duty_write_type;

   typedef struct {
      logic                         op;
      logic [GRP_W-1:0]             grp;
      logic [BYTE_W-1:0]            hue;
      logic [BYTE_W-1:0]            inten;
      logic [BYTE_W-1:0]            per;
      chk_kind_type                 chk;
      logic [NCH-1:0][DUTY_W-1:0]   frame;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OP_TICK;
   logic [GRP_W-1:0]    req_group = '0;
   logic [BYTE_W-1:0]   req_hue = '0;
   logic [BYTE_W-1:0]   req_intensity = '0;
   logic [BYTE_W-1:0]   req_fade_period = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CH_W-1:0]     rsp_channel;
   logic [DUTY_W-1:0]   rsp_duty;
   logic                rsp_last;

   // predictor state
   logic [DUTY_W-1:0]   goal_duty [NCH];
   logic [DUTY_W-1:0]   fade_duty [NCH];
   logic [BYTE_W-1:0]   fade_period [GROUPS];
   logic [BYTE_W-1:0]   fade_ticks [GROUPS];

   duty_write_type      tick_writes [$];
   duty_write_type      pending_writes [$];
   stim_row_type        directed [$];

   int errors = 0;
   int cycle_count = 0;
   int n_sets = 0, n_ticks = 0, n_ignored = 0, n_writes = 0, n_lasts = 0;
   int req_calm = 0, rsp_calm = 0;
   bit squeeze_armed = 1'b0, squeeze_done = 1'b0;

   rgb_led_fade_controller #(.GROUPS(GROUPS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_group       (req_group),
      .req_hue         (req_hue),
      .req_intensity   (req_intensity),
      .req_fade_period (req_fade_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_channel     (rsp_channel),
      .rsp_duty        (rsp_duty),
      .rsp_last        (rsp_last)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mismatch reporting, printing capped so a broken block stays readable
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // idle length: mostly none or short, a few long, with calm stretches
   function automatic int idle_len(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // full-saturation color conversion over 768 hue steps, duties scaled by four
   function automatic logic [COLORS-1:0][DUTY_W-1:0] hsb_to_duty(
      input logic [BYTE_W-1:0] hue, input logic [BYTE_W-1:0] bright);
      int h, b, n, x;
      int t [5];
      logic [COLORS-1:0][DUTY_W-1:0] d;
      h = 3 * int'(hue);
      b = int'(bright);
      n = h >> 8;
      x = ((((h & 255) * 255) >> 8) * b) >> 8;
      t[0] = 0;
      t[1] = x;
      t[2] = b - x;
      t[3] = 0;
      t[4] = x;
      d[COL_RED]   = DUTY_W'(t[n + 2] * 4);
      d[COL_GREEN] = DUTY_W'(t[n + 1] * 4);
      d[COL_BLUE]  = DUTY_W'(t[n] * 4);
      return d;
   endfunction

   // set color: new targets and fade period, out-of-range groups ignored
   task automatic apply_set(input logic [GRP_W-1:0] grp, input logic [BYTE_W-1:0] hue,
                            input logic [BYTE_W-1:0] inten, input logic [BYTE_W-1:0] per);
      logic [COLORS-1:0][DUTY_W-1:0] d;
      if (int'(grp) >= GROUPS) begin
         n_ignored++;
         return;
      end
      d = hsb_to_duty(hue, inten);
      for (int c = 0; c < COLORS; c++) begin
         goal_duty[int'(grp) * COLORS + c] = d[c];
      end
      fade_period[grp] = per;
   endtask

   // one tick: jump groups write targets, fading groups step when due
   task automatic apply_tick();
      int j;
      tick_writes.delete();
      for (int g = 0; g < GROUPS; g++) begin
         if (fade_period[g] == '0) begin
            for (int c = 0; c < COLORS; c++) begin
               j = g * COLORS + c;
               tick_writes.push_back('{CH_W'(j), goal_duty[j], 1'b0});
            end
         end else begin
            fade_ticks[g] = fade_ticks[g] + 1'b1;
            if (fade_ticks[g] >= fade_period[g]) begin
               for (int c = 0; c < COLORS; c++) begin
                  j = g * COLORS + c;
                  if (fade_duty[j] != goal_duty[j]) begin
                     tick_writes.push_back('{CH_W'(j), fade_duty[j], 1'b0});
                     if (fade_duty[j] < goal_duty[j]) fade_duty[j] = fade_duty[j] + 1'b1;
                     else fade_duty[j] = fade_duty[j] - 1'b1;
                  end
               end
               fade_ticks[g] = '0;
            end
         end
      end
      if (tick_writes.size() > 0) begin
         tick_writes[tick_writes.size() - 1].last = 1'b1;
      end
   endtask

   // offer one transfer and return at the edge that takes it
   task automatic offer(input stim_row_type row, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= row.op;
      req_group       <= row.grp;
      req_hue         <= row.hue;
      req_intensity   <= row.inten;
      req_fade_period <= row.per;
      do @(posedge clock); while (req_stall);
   endtask

   // predict the transfer just taken and queue its duty writes
   task automatic predict(input stim_row_type row);
      if (row.op == OP_SET) begin
         n_sets++;
         apply_set(row.grp, row.hue, row.inten, row.per);
         return;
      end
      n_ticks++;
      apply_tick();
      case (row.chk)
         CHK_FRAME: begin
            for (int j = 0; j < NCH; j++) begin
               pending_writes.push_back('{CH_W'(j), row.frame[j], j == NCH - 1});
            end
         end
         CHK_NONE: ;
         default: begin
            foreach (tick_writes[i]) pending_writes.push_back(tick_writes[i]);
         end
      endcase
   endtask

   task automatic add_row(input logic op, input int grp, input int hue, input int inten,
                          input int per, input chk_kind_type chk,
                          input logic [NCH-1:0][DUTY_W-1:0] frame);
      stim_row_type row;
      row.op    = op;
      row.grp   = GRP_W'(grp);
      row.hue   = BYTE_W'(hue);
      row.inten = BYTE_W'(inten);
      row.per   = BYTE_W'(per);
      row.chk   = chk;
      row.frame = frame;
      directed.push_back(row);
   endtask

   function automatic stim_row_type random_row();
      stim_row_type row;
      int r;
      row.chk   = CHK_MODEL;
      row.frame = FRAME_DARK;
      row.hue   = BYTE_W'($urandom);
      row.inten = BYTE_W'($urandom);
      row.per   = BYTE_W'($urandom);
      row.grp   = GRP_W'($urandom);
      if ($urandom_range(0, 99) >= 30) begin
         row.op = OP_TICK;
         return row;
      end
      row.op = OP_SET;
      row.grp = ($urandom_range(0, 99) < 8) ? GRP_W'(GROUPS) : GRP_W'($urandom_range(0, GROUPS-1));
      r = $urandom_range(0, 99);
      if (r < 5) row.hue = '0;
      else if (r < 10) row.hue = '1;
      // small intensities let fades actually reach their targets
      r = $urandom_range(0, 99);
      if (r < 45) row.inten = BYTE_W'($urandom_range(0, 7));
      else if (r < 50) row.inten = '1;
      r = $urandom_range(0, 99);
      if (r < 35) row.per = '0;
      else if (r < 85) row.per = BYTE_W'($urandom_range(1, 4));
      else if (r < 95) row.per = BYTE_W'($urandom_range(5, 20));
      else row.per = BYTE_W'($urandom_range(128, 255));
      return row;
   endfunction

   // result checking against the oldest expected duty write
   always @(posedge clock) begin
      duty_write_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_writes++;
         if (rsp_last) n_lasts++;
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write ch %0d duty %0d last %0d",
                                      rsp_channel, rsp_duty, rsp_last));
         end else begin
            want = pending_writes.pop_front();
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel %0d, expected %0d", rsp_channel, want.channel));
            if (rsp_duty !== want.duty)
               report_mismatch($sformatf("duty %0d on ch %0d, expected %0d",
                                         rsp_duty, want.channel, want.duty));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0d on ch %0d, expected %0d",
                                         rsp_last, want.channel, want.last));
         end
      end
   end

   // result side stalls, with one long hold-off to back the block up
   initial begin : rsp_side
      int s;
      forever begin
         if (squeeze_armed && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end else begin
            s = idle_len(rsp_calm);
            if (s > 0) begin
               rsp_stall <= 1'b1;
               repeat (s) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d writes still expected",
               cycle_count, pending_writes.size());
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus
   initial begin : req_side
      stim_row_type row;
      foreach (goal_duty[j]) begin
         goal_duty[j] = '0;
         fade_duty[j] = '0;
      end
      foreach (fade_period[g]) begin
         fade_period[g] = '0;
         fade_ticks[g]  = '0;
      end

      // directed table: reset state, extremes, ignored group, jump, slow and stuck fades
      add_row(OP_TICK, 0,   0,   0,   0, CHK_FRAME, FRAME_DARK);   // all zero after reset
      add_row(OP_SET,  0,   0, 255,   0, CHK_NONE,  FRAME_DARK);   // full red, jump
      add_row(OP_SET,  3,  85, 255,   0, CHK_NONE,  FRAME_DARK);   // group out of range
      add_row(OP_TICK, 0,   0,   0,   0, CHK_FRAME, FRAME_RED0);
      add_row(OP_SET,  1, 255, 255,   1, CHK_MODEL, FRAME_DARK);   // top of hue wheel
      add_row(OP_SET,  2,  85, 200,   2, CHK_MODEL, FRAME_DARK);
      repeat (4) add_row(OP_TICK, 1, 255, 255, 255, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  0, 170, 128,   3, CHK_MODEL, FRAME_DARK);
      repeat (2) add_row(OP_TICK, 2, 0, 0, 0, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  2,  85, 200, 200, CHK_MODEL, FRAME_DARK);   // long period, count grows
      repeat (3) add_row(OP_TICK, 0, 0, 0, 0, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  2,  85, 200,   1, CHK_MODEL, FRAME_DARK);   // period below count
      add_row(OP_TICK, 0,   0,   0,   0, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  0,   0,   0, 255, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  1,   0,   0, 255, CHK_MODEL, FRAME_DARK);
      add_row(OP_SET,  2, 128,   0, 255, CHK_MODEL, FRAME_DARK);
      add_row(OP_TICK, 3, 255, 255, 255, CHK_NONE,  FRAME_DARK);   // tick that writes nothing
      add_row(OP_SET,  1,  64,   6,   0, CHK_MODEL, FRAME_DARK);   // back to jump mode
      add_row(OP_TICK, 0,   0,   0,   0, CHK_MODEL, FRAME_DARK);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         offer(directed[i], idle_len(req_calm));
         predict(directed[i]);
      end

      // random part
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == SQUEEZE_AT) squeeze_armed = 1'b1;
         row = random_row();
         offer(row, idle_len(req_calm));
         predict(row);
      end
      req_valid <= 1'b0;

      // drain
      while (pending_writes.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transfers: %0d set color (%0d to absent groups), %0d ticks",
               directed.size() + RANDOM_ITEMS, n_sets, n_ignored, n_ticks);
      $display("%0d duty writes checked, %0d closing a tick, %0d mismatches, %0d cycles",
               n_writes, n_lasts, errors, cycle_count);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rlf_pkg.sv
hw/rtl/rlf_datapath.sv
hw/rtl/rlf_controller.sv
hw/rtl/rgb_led_fade_controller.sv
sim/rgb_led_fade_controller_tb.sv
